### rtl/ale_pkg.sv
`default_nettype none
package ale_pkg;
    localparam int CAPACITY = 64;
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_DEDUP   = 3'd2,
        CMD_REVERSE = 3'd3,
        CMD_ROTL    = 3'd4,
        CMD_ROTR    = 3'd5,
        CMD_SORTINS = 3'd6,
        CMD_DUMP    = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_BADK   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SHUP,
        S_SHDN,
        S_REVA,
        S_REVB,
        S_DEDUP,
        S_DUMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] value;
        logic [6:0]  position;
        logic [6:0]  shift_count;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  length;
        logic [31:0] element;
        logic        element_valid;
        logic        last;
    } t_out;
endpackage
`default_nettype wire

### rtl/ale_if.sv
`default_nettype none
interface ale_in_if;
    logic valid;
    logic ready;
    ale_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ale_out_if;
    logic valid;
    logic ready;
    ale_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/array_list_engine.sv
`default_nettype none
// array list engine: ordered list of signed words, one command per input word
// in channel: cmd, value, position, shift_count; taken one command at a time
// out channel: status, length, element, element_valid, last
// every command gives one result word, except dump which gives one per entry
// (or one empty word for an empty list), last set on the final word
// all list entries live in one 64-entry synchronous ram, one port read and one
// write per cycle, read data ready the cycle after the address
// insert/delete shift one entry at a time, a read then a write;
//   sorted insert first searches the entries in order, a read then a compare
//   per entry passed; reverse swaps a pair with two reads then two writes;
//   rotate runs three reversals; dedup reads each entry once and writes
//   only the kept ones; dump one word per cycle while the receiver takes them
// the single ram port sets this pacing
// reset clears the length, state and output valid; ram contents are undefined until written
// when the receiver stalls, the result word holds in the output register and
// the engine waits; a dump pauses its walk until the word is taken
module array_list_engine (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ale_in_if.sink    i_cmd,
    ale_out_if.source o_res
);
    import ale_pkg::*;

    logic [31:0] r_mem [CAPACITY];
    logic [31:0] r_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic rd_en, wr_en;
    logic [31:0] wr_data;

    t_state r_state, n_state;
    t_in r_cmd;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_i, n_i, r_j, n_j;    // working indexes
    logic [LW-1:0] r_rlo, n_rlo, r_rhi, n_rhi;
    logic [1:0] r_phase, n_phase;
    logic [1:0] r_pass, n_pass;
    logic [31:0] r_tmp, n_tmp;
    logic r_vld, n_vld;
    t_out r_out, n_out;
    logic r_pend, n_pend;                 // read data waiting in r_rd

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    assign i_cmd.ready = (r_state == S_IDLE) && !r_vld;
    assign o_res.valid = r_vld;
    assign o_res.data  = r_out;

    wire logic take = i_cmd.valid && i_cmd.ready;
    wire logic [LW-1:0] kk = r_cmd.shift_count[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len <= '0;
            r_vld <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len <= n_len;
            r_vld <= n_vld;
            r_pend <= n_pend;
        end
        r_cmd <= take ? i_cmd.data : r_cmd;
        r_i <= n_i; r_j <= n_j; r_rlo <= n_rlo; r_rhi <= n_rhi;
        r_phase <= n_phase; r_pass <= n_pass; r_tmp <= n_tmp; r_out <= n_out;
    end

    function automatic t_out done_word(input logic [1:0] s, input logic [LW-1:0] l);
        t_out w;
        w.status = s;
        w.length = 7'(l);
        w.element = '0;
        w.element_valid = 1'b0;
        w.last = 1'b1;
        return w;
    endfunction

    always_comb begin
        n_state = r_state;
        n_len = r_len; n_i = r_i; n_j = r_j; n_rlo = r_rlo; n_rhi = r_rhi;
        n_phase = r_phase; n_pass = r_pass; n_tmp = r_tmp;
        n_out = r_out;
        n_vld = r_vld && !o_res.ready;
        n_pend = 1'b0;
        rd_en = 1'b0; rd_addr = '0;
        wr_en = 1'b0; wr_addr = '0; wr_data = r_cmd.value;
        unique case (r_state)
            S_IDLE: if (take) begin
                n_phase = '0;
                unique case (t_cmd'(i_cmd.data.cmd))
                    CMD_INSERT, CMD_SORTINS: begin
                        if (r_len == LW'(CAPACITY)) begin
                            n_out = done_word(ST_FULL, r_len); n_state = S_OUT;
                        end else if (i_cmd.data.cmd == CMD_INSERT &&
                                     (i_cmd.data.position == 7'd0 ||
                                      i_cmd.data.position > 7'(r_len) + 7'd1)) begin
                            n_out = done_word(ST_BADPOS, r_len); n_state = S_OUT;
                        end else if (i_cmd.data.cmd == CMD_INSERT) begin
                            n_i = LW'(i_cmd.data.position - 7'd1);
                            n_j = r_len; n_state = S_SHUP;
                        end else begin
                            n_i = '0; n_state = S_SEARCH;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_cmd.data.position == 7'd0 ||
                            i_cmd.data.position > 7'(r_len)) begin
                            n_out = done_word(ST_BADPOS, r_len); n_state = S_OUT;
                        end else begin
                            n_j = LW'(i_cmd.data.position - 7'd1); n_state = S_SHDN;
                        end
                    end
                    CMD_DEDUP: begin
                        n_i = '0; n_j = LW'(1); n_state = S_DEDUP;
                    end
                    CMD_REVERSE: begin
                        n_pass = 2'd2; n_rlo = '0; n_rhi = r_len; n_state = S_REVA;
                    end
                    CMD_ROTL, CMD_ROTR: begin
                        if (i_cmd.data.shift_count > 7'(r_len)) begin
                            n_out = done_word(ST_BADK, r_len); n_state = S_OUT;
                        end else begin
                            // split point m; passes: [0,m) [m,len) [0,len)
                            n_pass = 2'd0; n_rlo = '0;
                            n_rhi = (i_cmd.data.cmd == CMD_ROTL) ?
                                    LW'(i_cmd.data.shift_count) :
                                    r_len - LW'(i_cmd.data.shift_count);
                            n_tmp = 32'(n_rhi);
                            n_state = S_REVA;
                        end
                    end
                    default: begin
                        if (r_len == '0) begin
                            n_out = done_word(ST_OK, r_len); n_state = S_OUT;
                        end else begin
                            n_i = '0; n_j = '0; n_state = S_DUMP;
                        end
                    end
                endcase
            end
            S_SEARCH: begin
                // phase 0 issue read i; phase 1 compare
                if (r_phase == 2'd0) begin
                    if (r_i == r_len) begin
                        n_j = r_len; n_state = S_SHUP;
                    end else begin
                        rd_en = 1'b1; rd_addr = r_i[AW-1:0]; n_phase = 2'd1;
                    end
                end else begin
                    n_phase = 2'd0;
                    if ($signed(r_rd) < $signed(r_cmd.value)) n_i = r_i + 1'b1;
                    else begin
                        n_j = r_len; n_state = S_SHUP;
                    end
                end
            end
            S_SHUP: begin
                // move store[j-1] to store[j] for j down to i+1, then write i
                if (r_phase == 2'd0) begin
                    if (r_j == r_i) begin
                        wr_en = 1'b1; wr_addr = r_i[AW-1:0]; wr_data = r_cmd.value;
                        n_len = r_len + 1'b1;
                        n_out = done_word(ST_OK, r_len + 1'b1); n_state = S_OUT;
                    end else begin
                        rd_en = 1'b1; rd_addr = AW'(r_j - 1'b1); n_phase = 2'd1;
                    end
                end else begin
                    wr_en = 1'b1; wr_addr = r_j[AW-1:0]; wr_data = r_rd;
                    n_j = r_j - 1'b1; n_phase = 2'd0;
                end
            end
            S_SHDN: begin
                if (r_phase == 2'd0) begin
                    if (r_j + 1'b1 >= r_len) begin
                        n_len = r_len - 1'b1;
                        n_out = done_word(ST_OK, r_len - 1'b1); n_state = S_OUT;
                    end else begin
                        rd_en = 1'b1; rd_addr = AW'(r_j + 1'b1); n_phase = 2'd1;
                    end
                end else begin
                    wr_en = 1'b1; wr_addr = r_j[AW-1:0]; wr_data = r_rd;
                    n_j = r_j + 1'b1; n_phase = 2'd0;
                end
            end
            S_REVA: begin
                // swap lo and hi-1: read lo, read hi-1, write lo, write hi-1
                unique case (r_phase)
                    2'd0: begin
                        if (r_rlo + 1'b1 >= r_rhi) begin
                            n_state = S_REVB;
                        end else begin
                            rd_en = 1'b1; rd_addr = r_rlo[AW-1:0]; n_phase = 2'd1;
                        end
                    end
                    2'd1: begin
                        n_tmp = r_rd; rd_en = 1'b1; rd_addr = AW'(r_rhi - 1'b1);
                        n_phase = 2'd2;
                    end
                    2'd2: begin
                        wr_en = 1'b1; wr_addr = r_rlo[AW-1:0]; wr_data = r_rd;
                        n_phase = 2'd3;
                    end
                    default: begin
                        wr_en = 1'b1; wr_addr = AW'(r_rhi - 1'b1); wr_data = r_tmp;
                        n_rlo = r_rlo + 1'b1; n_rhi = r_rhi - 1'b1; n_phase = 2'd0;
                    end
                endcase
            end
            S_REVB: begin
                // next pass of a rotate, or done; tmp is busy so m is rederived
                n_phase = 2'd0;
                n_state = S_REVA;
                unique case (r_pass)
                    2'd0: begin
                        n_pass = 2'd1;
                        n_rlo = (r_cmd.cmd == CMD_ROTL) ? kk : r_len - kk;
                        n_rhi = r_len;
                    end
                    2'd1: begin
                        n_pass = 2'd2; n_rlo = '0; n_rhi = r_len;
                    end
                    default: begin
                        n_out = done_word(ST_OK, r_len); n_state = S_OUT;
                    end
                endcase
            end
            S_DEDUP: begin
                // i: last kept index, j: next candidate; compaction in place
                unique case (r_phase)
                    2'd0: begin
                        if (r_len == '0) begin
                            n_out = done_word(ST_OK, r_len); n_state = S_OUT;
                        end else begin
                            rd_en = 1'b1; rd_addr = '0; n_phase = 2'd1;
                        end
                    end
                    2'd1: begin
                        n_tmp = r_rd; n_phase = 2'd2;
                    end
                    2'd2: begin
                        if (r_j >= r_len) begin
                            n_len = r_i + 1'b1;
                            n_out = done_word(ST_OK, r_i + 1'b1); n_state = S_OUT;
                        end else begin
                            rd_en = 1'b1; rd_addr = r_j[AW-1:0]; n_phase = 2'd3;
                        end
                    end
                    default: begin
                        n_j = r_j + 1'b1; n_phase = 2'd2;
                        if (r_rd != r_tmp) begin
                            wr_en = 1'b1; wr_addr = AW'(r_i + 1'b1); wr_data = r_rd;
                            n_i = r_i + 1'b1; n_tmp = r_rd;
                        end
                    end
                endcase
            end
            S_DUMP: begin
                // i: next read address, pend: word for i-1 ready in r_rd
                if (r_pend && !n_vld) begin
                    n_vld = 1'b1;
                    n_out.status = ST_OK; n_out.length = 7'(r_len);
                    n_out.element = r_rd; n_out.element_valid = 1'b1;
                    n_out.last = (r_j + 1'b1 == r_len);
                    n_j = r_j + 1'b1;
                    if (r_j + 1'b1 == r_len) n_state = S_IDLE;
                end
                if (r_pend && n_vld && !(r_pend && !r_vld) && r_vld && !o_res.ready) begin
                    n_pend = 1'b1;  // hold word in r_rd
                end else if (r_pend && r_vld && !o_res.ready) begin
                    n_pend = 1'b1;
                end else if (r_i < r_len) begin
                    rd_en = 1'b1; rd_addr = r_i[AW-1:0]; n_pend = 1'b1;
                    n_i = r_i + 1'b1;
                end
            end
            default: begin
                if (!n_vld) begin
                    n_vld = 1'b1; n_state = S_IDLE;
                end
            end
        endcase
    end

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("length above capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.data))
        else $error("result word changed under stall");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE || r_state == S_OUT || r_state == S_DUMP |-> !wr_en)
        else $error("ram written outside an edit");
    a_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |=> $stable(r_len))
        else $error("length changed during dump");
endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import ale_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ale_in_if  cmd_ch ();
    ale_out_if res_ch ();

    array_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted list contents
    logic [31:0] shadow_list [CAPACITY];
    int unsigned shadow_len;

    t_in  pending_cmds [$];
    t_out expected_words [$];
    int   mismatch_count = 0;
    bit   stim_done = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void flip_span(int unsigned lo, int unsigned hi);
        logic [31:0] t;
        while (lo + 1 < hi) begin
            t = shadow_list[lo];
            shadow_list[lo] = shadow_list[hi - 1];
            shadow_list[hi - 1] = t;
            lo++;
            hi--;
        end
    endfunction

    function automatic void open_slot(int unsigned idx, logic [31:0] v);
        for (int unsigned q = shadow_len; q > idx; q--) shadow_list[q] = shadow_list[q - 1];
        shadow_list[idx] = v;
        shadow_len++;
    endfunction

    function automatic void close_slot(int unsigned idx);
        for (int unsigned q = idx; q + 1 < shadow_len; q++) shadow_list[q] = shadow_list[q + 1];
        shadow_len--;
    endfunction

    function automatic void push_word(t_status st, logic [31:0] el, logic ev, logic lst);
        t_out w;
        w.status = st;
        w.length = shadow_len[6:0];
        w.element = el;
        w.element_valid = ev;
        w.last = lst;
        expected_words.push_back(w);
    endfunction

    function automatic void predict_list_op(t_in c);
        t_status st;
        int unsigned i, k;
        st = ST_OK;
        case (t_cmd'(c.cmd))
            CMD_INSERT: begin
                if (shadow_len >= CAPACITY) st = ST_FULL;
                else if (c.position < 1 || c.position > shadow_len + 1) st = ST_BADPOS;
                else open_slot(c.position - 1, c.value);
            end
            CMD_DELETE: begin
                if (c.position < 1 || c.position > shadow_len) st = ST_BADPOS;
                else close_slot(c.position - 1);
            end
            CMD_DEDUP: begin
                i = 0;
                while (i + 1 < shadow_len) begin
                    if (shadow_list[i] == shadow_list[i + 1]) close_slot(i + 1);
                    else i++;
                end
            end
            CMD_REVERSE: flip_span(0, shadow_len);
            CMD_ROTL, CMD_ROTR: begin
                if (c.shift_count > shadow_len) st = ST_BADK;
                else begin
                    k = (c.cmd == CMD_ROTL) ? c.shift_count : shadow_len - c.shift_count;
                    flip_span(0, k);
                    flip_span(k, shadow_len);
                    flip_span(0, shadow_len);
                end
            end
            CMD_SORTINS: begin
                if (shadow_len >= CAPACITY) st = ST_FULL;
                else begin
                    i = 0;
                    while (i < shadow_len && $signed(shadow_list[i]) < $signed(c.value)) i++;
                    open_slot(i, c.value);
                end
            end
            default: begin
                if (shadow_len == 0) push_word(ST_OK, '0, 1'b0, 1'b1);
                for (i = 0; i < shadow_len; i++)
                    push_word(ST_OK, shadow_list[i], 1'b1, i + 1 == shadow_len);
                return;
            end
        endcase
        push_word(st, '0, 1'b0, 1'b1);
    endfunction

    function automatic t_in mk_cmd(t_cmd op, logic [31:0] v, logic [6:0] p, logic [6:0] k);
        t_in c;
        c.cmd = op;
        c.value = v;
        c.position = p;
        c.shift_count = k;
        return c;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (cmd_ch.valid && !cmd_ch.ready) begin
            // hold word
        end else begin
            if (cmd_ch.valid) predict_list_op(cmd_ch.data);
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                cmd_ch.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cmd_ch.data <= pending_cmds.pop_front();
                cmd_ch.valid <= 1'b1;
                in_gap <= pick_gap();
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out w;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected word %p", res_ch.data);
                end else begin
                    w = expected_words.pop_front();
                    if (res_ch.data !== w) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", w, res_ch.data);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                out_gap <= pick_gap();
            end
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || cmd_ch.valid || expected_words.size() > 0)
            @(posedge i_clk);
    endtask

    function automatic t_in rand_cmd(int unsigned len);
        t_in c;
        int r;
        r = $urandom_range(0, 99);
        c.value = $urandom();
        if ($urandom_range(0, 3) == 0) c.value = $urandom_range(0, 7) - 4;
        c.position = (len == 0 || $urandom_range(0, 9) == 0) ?
            7'($urandom_range(0, 127)) : 7'($urandom_range(1, len + 1));
        c.shift_count = ($urandom_range(0, 9) == 0) ?
            7'($urandom_range(0, 127)) : 7'($urandom_range(0, len));
        if (r < 35) c.cmd = CMD_INSERT;
        else if (r < 45) c.cmd = CMD_DELETE;
        else if (r < 52) c.cmd = CMD_DEDUP;
        else if (r < 59) c.cmd = CMD_REVERSE;
        else if (r < 67) c.cmd = CMD_ROTL;
        else if (r < 75) c.cmd = CMD_ROTR;
        else if (r < 90) c.cmd = CMD_SORTINS;
        else c.cmd = CMD_DUMP;
        return c;
    endfunction

    initial begin
        int unsigned len;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        res_ch.ready = 1'b0;
        shadow_len = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list corners, then extremes
        pending_cmds.push_back(mk_cmd(CMD_DUMP, '0, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_DEDUP, '0, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_REVERSE, '0, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_ROTL, '0, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_ROTR, '0, 7'd0, 7'd1));
        pending_cmds.push_back(mk_cmd(CMD_DELETE, '0, 7'd1, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_INSERT, 32'h7fffffff, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_INSERT, 32'h7fffffff, 7'd1, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_INSERT, 32'h80000000, 7'd3, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_INSERT, 32'h80000000, 7'd2, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_INSERT, 32'h80000000, 7'd127, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_SORTINS, 32'hffffffff, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_SORTINS, 32'h00000000, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_INSERT, 32'h0, 7'd5, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_DUMP, '0, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_DEDUP, '0, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_ROTL, '0, 7'd0, 7'd2));
        pending_cmds.push_back(mk_cmd(CMD_ROTR, '0, 7'd0, 7'd4));
        pending_cmds.push_back(mk_cmd(CMD_ROTL, '0, 7'd0, 7'd127));
        pending_cmds.push_back(mk_cmd(CMD_REVERSE, '0, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_DELETE, '0, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_DELETE, '0, 7'd4, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_DELETE, '0, 7'd1, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_DUMP, '0, 7'd0, 7'd0));
        wait_drained();

        // fill to capacity with sorted inserts, then hit the full cases
        for (int n = 0; n < CAPACITY + 2; n++) begin
            pending_cmds.push_back(mk_cmd(CMD_SORTINS, $urandom_range(0, 15) - 8, 7'd0, 7'd0));
            wait_drained();
        end
        pending_cmds.push_back(mk_cmd(CMD_INSERT, 32'h1, 7'd1, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_ROTL, '0, 7'd0, 7'd64));
        pending_cmds.push_back(mk_cmd(CMD_ROTR, '0, 7'd0, 7'd65));
        pending_cmds.push_back(mk_cmd(CMD_DUMP, '0, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_DEDUP, '0, 7'd0, 7'd0));
        pending_cmds.push_back(mk_cmd(CMD_DUMP, '0, 7'd0, 7'd0));
        wait_drained();

        // random: one at a time so the field ranges track the list length
        for (int n = 0; n < 23; n++) begin
            len = shadow_len;
            pending_cmds.push_back(rand_cmd(len));
            wait_drained();
        end
        pending_cmds.push_back(mk_cmd(CMD_DUMP, '0, 7'd0, 7'd0));
        wait_drained();
        repeat (200) @(posedge i_clk);

        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

### sim.f
rtl/ale_pkg.sv
rtl/ale_if.sv
rtl/array_list_engine.sv
sim/tb_top.sv
